/* rtl/sdf_pkg.sv */
package sdf_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int GAIN_BITS     = 16;
    localparam int POS_BITS      = 32;
    localparam int DIFF_BITS     = 33;
    localparam int MAG_BITS      = 32;
    localparam int SQ_BITS       = 64;
    localparam int RAD_BITS      = 66;
    localparam int ROOT_BITS     = 33;
    localparam int REM_BITS      = 34;
    localparam int REST_BITS     = 31;
    localparam int LANES         = 3;

    localparam logic REG_STIFFNESS = 1'b0;
    localparam logic REG_DAMPING   = 1'b1;

    localparam logic [GAIN_BITS-1:0] STIFFNESS_RESET = 16'd6554;
    localparam logic [GAIN_BITS-1:0] DAMPING_RESET   = 16'd32768;

    typedef struct packed {
        logic signed [31:0] first_x;
        logic signed [31:0] first_y;
        logic signed [31:0] first_z;
        logic signed [31:0] second_x;
        logic signed [31:0] second_y;
        logic signed [31:0] second_z;
        logic signed [31:0] rel_motion_x;
        logic signed [31:0] rel_motion_y;
        logic signed [31:0] rel_motion_z;
        logic [30:0]        rest_length;
    } item_t;

    typedef struct packed {
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic               zero_length;
    } result_t;

    typedef struct packed {
        logic [LANES-1:0]                 sign;
        logic [LANES-1:0][MAG_BITS-1:0]   mag;
        logic [LANES-1:0][POS_BITS-1:0]   rel;
        logic [REST_BITS-1:0]             rest;
        logic                             zero;
    } side_t;

    typedef struct packed {
        logic en;
        logic valid;
    } flow_t;

endpackage

/* rtl/sdf_sqrt_pipe.sv */
module sdf_sqrt_pipe
    import sdf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  flow_t                flow_in,
    input  logic [RAD_BITS-1:0]  rad,
    input  side_t                side_in,
    output logic                 out_valid,
    output logic [ROOT_BITS-1:0] root,
    output side_t                side_out
);

    logic                 valid_reg [1:ROOT_BITS];
    logic [ROOT_BITS-1:0] root_reg  [1:ROOT_BITS];
    side_t                side_reg  [1:ROOT_BITS];
    logic [RAD_BITS-1:0]  rem_reg   [1:ROOT_BITS-1];

    for (genvar k = 0; k < ROOT_BITS; k++)
    begin : g_stage
        localparam int B = ROOT_BITS - 1 - k;
        logic                 valid_cur;
        logic [ROOT_BITS-1:0] root_cur;
        side_t                side_cur;
        logic [RAD_BITS-1:0]  rem_cur;
        logic [RAD_BITS-1:0]  trial;
        logic                 take;

        if (k == 0)
        begin : g_first
            assign valid_cur = flow_in.valid;
            assign root_cur  = '0;
            assign side_cur  = side_in;
            assign rem_cur   = rad;
        end
        else
        begin : g_next
            assign valid_cur = valid_reg[k];
            assign root_cur  = root_reg[k];
            assign side_cur  = side_reg[k];
            assign rem_cur   = rem_reg[k];
        end

        assign trial = (RAD_BITS'(root_cur) << (B + 1)) | (RAD_BITS'(1) << (2 * B));
        assign take  = rem_cur >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else if (flow_in.en)
            begin
                valid_reg[k+1] <= valid_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (flow_in.en)
            begin
                root_reg[k+1] <= take ? (root_cur | (ROOT_BITS'(1) << B)) : root_cur;
                side_reg[k+1] <= side_cur;
            end
        end

        if (k < ROOT_BITS - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (flow_in.en)
                begin
                    rem_reg[k+1] <= take ? (rem_cur - trial) : rem_cur;
                end
            end
        end
    end

    assign out_valid = valid_reg[ROOT_BITS];
    assign root      = root_reg[ROOT_BITS];
    assign side_out  = side_reg[ROOT_BITS];

endmodule

/* rtl/sdf_div_pipe.sv */
module sdf_div_pipe
    import sdf_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  flow_t                           flow_in,
    input  logic                            in_valid,
    input  logic [ROOT_BITS-1:0]            den,
    input  side_t                           side_in,
    output logic                            out_valid,
    output logic [LANES-1:0][FRAC_BITS:0]   quot,
    output logic [ROOT_BITS-1:0]            den_out,
    output side_t                           side_out
);

    localparam int STEPS = FRAC_BITS + 1;

    logic                               valid_reg [1:STEPS];
    logic [LANES-1:0][FRAC_BITS:0]      q_reg     [1:STEPS];
    logic [ROOT_BITS-1:0]               den_reg   [1:STEPS];
    side_t                              side_reg  [1:STEPS];
    logic [LANES-1:0][REM_BITS-1:0]     rem_reg   [1:STEPS-1];

    for (genvar k = 0; k < STEPS; k++)
    begin : g_stage
        logic                           valid_cur;
        logic [LANES-1:0][FRAC_BITS:0]  q_cur;
        logic [ROOT_BITS-1:0]           den_cur;
        side_t                          side_cur;
        logic [LANES-1:0][REM_BITS-1:0] rem_cur;
        logic [LANES-1:0][FRAC_BITS:0]  q_next;
        logic [LANES-1:0][REM_BITS-1:0] rem_next;

        if (k == 0)
        begin : g_first
            assign valid_cur = in_valid;
            assign q_cur     = '0;
            assign den_cur   = den;
            assign side_cur  = side_in;
            for (genvar i = 0; i < LANES; i++)
            begin : g_init
                assign rem_cur[i] = REM_BITS'(side_in.mag[i]);
            end
        end
        else
        begin : g_next
            assign valid_cur = valid_reg[k];
            assign q_cur     = q_reg[k];
            assign den_cur   = den_reg[k];
            assign side_cur  = side_reg[k];
            assign rem_cur   = rem_reg[k];
        end

        always_comb
        begin
            for (int i = 0; i < LANES; i++)
            begin
                if (rem_cur[i] >= REM_BITS'(den_cur))
                begin
                    q_next[i]   = {q_cur[i][FRAC_BITS-1:0], 1'b1};
                    rem_next[i] = (rem_cur[i] - REM_BITS'(den_cur)) << 1;
                end
                else
                begin
                    q_next[i]   = {q_cur[i][FRAC_BITS-1:0], 1'b0};
                    rem_next[i] = rem_cur[i] << 1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else if (flow_in.en)
            begin
                valid_reg[k+1] <= valid_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (flow_in.en)
            begin
                q_reg[k+1]    <= q_next;
                den_reg[k+1]  <= den_cur;
                side_reg[k+1] <= side_cur;
            end
        end

        if (k < STEPS - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (flow_in.en)
                begin
                    rem_reg[k+1] <= rem_next;
                end
            end
        end
    end

    assign out_valid = valid_reg[STEPS];
    assign quot      = q_reg[STEPS];
    assign den_out   = den_reg[STEPS];
    assign side_out  = side_reg[STEPS];

endmodule

/* rtl/sdf_force_pipe.sv */
module sdf_force_pipe
    import sdf_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  flow_t                         flow_in,
    input  logic                          in_valid,
    input  logic [LANES-1:0][FRAC_BITS:0] quot,
    input  logic [ROOT_BITS-1:0]          len,
    input  side_t                         side_in,
    input  logic [GAIN_BITS-1:0]          stiffness_gain,
    input  logic [GAIN_BITS-1:0]          damping_gain,
    output logic                          out_valid,
    output result_t                       result
);

    localparam int NW    = FRAC_BITS + 2;
    localparam int PW    = NW + POS_BITS;
    localparam int SW    = PW + 2;
    localparam int DOTW  = SW - FRAC_BITS;
    localparam int DIFW  = ROOT_BITS + 2;
    localparam int SPW   = DIFW + GAIN_BITS + 1;
    localparam int SPRW  = SPW - GAIN_BITS;
    localparam int DMW   = DOTW + GAIN_BITS + 1;
    localparam int DMRW  = DMW - GAIN_BITS;
    localparam int TW    = DMRW + 1;
    localparam int FW    = TW + NW;
    localparam int VW    = FW - FRAC_BITS;

    logic [7:1] valid_reg;
    logic [7:1] zero_reg;

    logic signed [NW-1:0]   n1_reg [LANES];
    logic signed [NW-1:0]   n2_reg [LANES];
    logic signed [NW-1:0]   n3_reg [LANES];
    logic signed [NW-1:0]   n4_reg [LANES];
    logic signed [NW-1:0]   n5_reg [LANES];
    logic signed [31:0]     rel1_reg [LANES];
    logic signed [DIFW-1:0] diff1_reg;
    logic signed [PW-1:0]   p2_reg [LANES];
    logic signed [SPW-1:0]  sp2_reg;
    logic signed [DOTW-1:0] dot3_reg;
    logic signed [SPRW-1:0] spring3_reg;
    logic signed [SPRW-1:0] spring4_reg;
    logic signed [DMW-1:0]  dm4_reg;
    logic signed [TW-1:0]   t5_reg;
    logic signed [FW-1:0]   f6_reg [LANES];
    logic signed [31:0]     force7_reg [LANES];

    logic signed [SW-1:0]   dot_sum;
    logic signed [VW-1:0]   scaled [LANES];
    logic signed [31:0]     force_next [LANES];

    always_comb
    begin
        dot_sum = SW'(p2_reg[0]) + SW'(p2_reg[1]) + SW'(p2_reg[2]);
        for (int i = 0; i < LANES; i++)
        begin
            scaled[i] = VW'(f6_reg[i] >>> FRAC_BITS);
            if (zero_reg[6])
            begin
                force_next[i] = '0;
            end
            else if ((&scaled[i][VW-1:31]) || !(|scaled[i][VW-1:31]))
            begin
                force_next[i] = scaled[i][31:0];
            end
            else if (scaled[i][VW-1])
            begin
                force_next[i] = 32'sh8000_0000;
            end
            else
            begin
                force_next[i] = 32'sh7fff_ffff;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (flow_in.en)
        begin
            valid_reg <= {valid_reg[6:1], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (flow_in.en)
        begin
            zero_reg <= {zero_reg[6:1], side_in.zero};
            for (int i = 0; i < LANES; i++)
            begin
                n1_reg[i]   <= side_in.sign[i] ? -$signed(NW'(quot[i]))
                                               : $signed(NW'(quot[i]));
                rel1_reg[i] <= $signed(side_in.rel[i]);
                p2_reg[i]   <= PW'(n1_reg[i]) * PW'(rel1_reg[i]);
                n2_reg[i]   <= n1_reg[i];
                n3_reg[i]   <= n2_reg[i];
                n4_reg[i]   <= n3_reg[i];
                n5_reg[i]   <= n4_reg[i];
                f6_reg[i]   <= FW'(t5_reg) * FW'(n5_reg[i]);
                force7_reg[i] <= force_next[i];
            end
            diff1_reg   <= $signed(DIFW'(len)) - $signed(DIFW'(side_in.rest));
            sp2_reg     <= SPW'(diff1_reg) * $signed(SPW'(stiffness_gain));
            dot3_reg    <= DOTW'(dot_sum >>> FRAC_BITS);
            spring3_reg <= SPRW'(sp2_reg >>> GAIN_BITS);
            dm4_reg     <= DMW'(dot3_reg) * $signed(DMW'(damping_gain));
            spring4_reg <= spring3_reg;
            t5_reg      <= TW'(spring4_reg) - TW'(dm4_reg >>> GAIN_BITS);
        end
    end

    assign out_valid          = valid_reg[7];
    assign result.force_x     = force7_reg[0];
    assign result.force_y     = force7_reg[1];
    assign result.force_z     = force7_reg[2];
    assign result.zero_length = zero_reg[7];

endmodule

/* rtl/spring_damper_force_core.sv */
// Channel  | Signals                          | Beat
// item     | item_valid, item_ready, item     | two positions, relative motion, rest
// result   | result_valid, result_ready, result | force on first particle, zero flag
// config   | cfg_we, cfg_index, cfg_data      | one gain register write
//
// One beat per cycle in and out, except while the pipeline holds on a waiting result.
// The pipeline depth is set by the bit-per-stage square root and the bit-per-stage dividers.
// rst_n clears all valid bits and loads the default gains.
// The whole pipeline holds while a result waits and result_ready is low.
module spring_damper_force_core
    import sdf_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  item_t                item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output result_t              result,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [GAIN_BITS-1:0] cfg_data
);

    logic [GAIN_BITS-1:0] stiffness_gain_reg;
    logic [GAIN_BITS-1:0] damping_gain_reg;

    flow_t flow;

    logic signed [POS_BITS-1:0] pos_a [LANES];
    logic signed [POS_BITS-1:0] pos_b [LANES];
    logic [LANES-1:0][POS_BITS-1:0] rel_in;

    logic                           va_reg, vb_reg, vc_reg, vd_reg;
    logic signed [DIFF_BITS-1:0]    d_reg [LANES];
    logic [LANES-1:0][POS_BITS-1:0] rel_a_reg;
    logic [REST_BITS-1:0]           rest_a_reg;
    side_t                          side_b_reg;
    logic [SQ_BITS-1:0]             sq_reg [LANES];
    side_t                          side_c_reg;
    logic [RAD_BITS-1:0]            rad_reg;
    side_t                          side_d_reg;

    logic                          sqrt_valid;
    logic [ROOT_BITS-1:0]          root;
    side_t                         sqrt_side;
    logic                          div_valid;
    logic [LANES-1:0][FRAC_BITS:0] quot;
    logic [ROOT_BITS-1:0]          len;
    side_t                         div_side;

    assign flow.en    = !result_valid || result_ready;
    assign flow.valid = vd_reg;
    assign item_ready = flow.en;

    assign pos_a[0] = item.first_x;
    assign pos_a[1] = item.first_y;
    assign pos_a[2] = item.first_z;
    assign pos_b[0] = item.second_x;
    assign pos_b[1] = item.second_y;
    assign pos_b[2] = item.second_z;
    assign rel_in   = {item.rel_motion_z, item.rel_motion_y, item.rel_motion_x};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stiffness_gain_reg <= STIFFNESS_RESET;
            damping_gain_reg   <= DAMPING_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_STIFFNESS: stiffness_gain_reg <= cfg_data;
                REG_DAMPING:   damping_gain_reg   <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else if (flow.en)
        begin
            va_reg <= item_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (flow.en)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                d_reg[i] <= DIFF_BITS'(pos_b[i]) - DIFF_BITS'(pos_a[i]);
                side_b_reg.sign[i] <= d_reg[i][DIFF_BITS-1];
                side_b_reg.mag[i]  <= d_reg[i][DIFF_BITS-1] ? MAG_BITS'(-d_reg[i])
                                                           : MAG_BITS'(d_reg[i]);
                sq_reg[i] <= SQ_BITS'(side_b_reg.mag[i]) * SQ_BITS'(side_b_reg.mag[i]);
            end
            rel_a_reg  <= rel_in;
            rest_a_reg <= item.rest_length;

            side_b_reg.rel  <= rel_a_reg;
            side_b_reg.rest <= rest_a_reg;
            side_b_reg.zero <= (d_reg[0] == '0) && (d_reg[1] == '0) && (d_reg[2] == '0);

            side_c_reg <= side_b_reg;

            rad_reg    <= RAD_BITS'(sq_reg[0]) + RAD_BITS'(sq_reg[1]) + RAD_BITS'(sq_reg[2]);
            side_d_reg <= side_c_reg;
        end
    end

    sdf_sqrt_pipe u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .flow_in   (flow),
        .rad       (rad_reg),
        .side_in   (side_d_reg),
        .out_valid (sqrt_valid),
        .root      (root),
        .side_out  (sqrt_side)
    );

    sdf_div_pipe #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .flow_in   (flow),
        .in_valid  (sqrt_valid),
        .den       (root),
        .side_in   (sqrt_side),
        .out_valid (div_valid),
        .quot      (quot),
        .den_out   (len),
        .side_out  (div_side)
    );

    sdf_force_pipe #(
        .FRAC_BITS (FRAC_BITS)
    ) u_force (
        .clk            (clk),
        .rst_n          (rst_n),
        .flow_in        (flow),
        .in_valid       (div_valid),
        .quot           (quot),
        .len            (len),
        .side_in        (div_side),
        .stiffness_gain (stiffness_gain_reg),
        .damping_gain   (damping_gain_reg),
        .out_valid      (result_valid),
        .result         (result)
    );

`ifndef SYNTH
    a_zero_force: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.zero_length |->
            result.force_x == 0 && result.force_y == 0 && result.force_z == 0)
        else $error("zero-length spring with nonzero force");

    a_root_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_valid && !sqrt_side.zero |-> root != '0)
        else $error("zero length for separated particles");

    a_unit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        div_valid && !div_side.zero |->
            quot[0] <= (FRAC_BITS+1)'(1) << FRAC_BITS &&
            quot[1] <= (FRAC_BITS+1)'(1) << FRAC_BITS &&
            quot[2] <= (FRAC_BITS+1)'(1) << FRAC_BITS)
        else $error("direction component above one");
`endif

endmodule

/* bench/tb_spring_damper_force_core.sv */
`timescale 1ns / 100ps

module tb_spring_damper_force_core;
    import sdf_pkg::*;

    localparam int FB = 16;
    localparam int LATENCY = 4 + 33 + (FB + 1) + 7;
    localparam int STALL_LIMIT = 20000;

    class force_scoreboard;
        logic [GAIN_BITS-1:0] stiff;
        logic [GAIN_BITS-1:0] damp;
        result_t pending[$];
        int errors;

        function new();
            stiff = STIFFNESS_RESET;
            damp = DAMPING_RESET;
            errors = 0;
        endfunction

        function logic signed [63:0] floor_shr(logic signed [63:0] v, int s);
            return v >>> s;
        endfunction

        function logic [32:0] isqrt(logic [65:0] s);
            logic [32:0] r;
            logic [32:0] c;
            r = '0;
            for (int b = 32; b >= 0; b--)
            begin
                c = r | (33'd1 << b);
                if ({33'd0, c} * {33'd0, c} <= s)
                    r = c;
            end
            return r;
        endfunction

        function logic signed [31:0] sat(logic signed [63:0] v);
            if (v > 64'sd2147483647)
                return 32'sh7fffffff;
            if (v < -64'sd2147483648)
                return 32'sh80000000;
            return v[31:0];
        endfunction

        function void note_item(item_t it);
            logic signed [63:0] d[3];
            logic signed [63:0] rel[3];
            logic signed [63:0] n[3];
            logic [63:0] m;
            logic [65:0] sumsq;
            logic [32:0] len;
            logic signed [63:0] dotsum, dotv, spr, dmp, t;
            result_t r;
            d[0] = 64'(it.second_x) - 64'(it.first_x);
            d[1] = 64'(it.second_y) - 64'(it.first_y);
            d[2] = 64'(it.second_z) - 64'(it.first_z);
            rel[0] = 64'(it.rel_motion_x);
            rel[1] = 64'(it.rel_motion_y);
            rel[2] = 64'(it.rel_motion_z);
            sumsq = '0;
            for (int i = 0; i < 3; i++)
            begin
                m = d[i] < 0 ? -d[i] : d[i];
                sumsq += 66'(m) * 66'(m);
            end
            r = '0;
            if (sumsq == 0)
            begin
                r.zero_length = 1'b1;
                pending.push_back(r);
                return;
            end
            len = isqrt(sumsq);
            dotsum = 0;
            for (int i = 0; i < 3; i++)
            begin
                m = d[i] < 0 ? -d[i] : d[i];
                m = (m << FB) / {31'd0, len};
                n[i] = d[i] < 0 ? -$signed(m) : $signed(m);
                dotsum += n[i] * rel[i];
            end
            dotv = floor_shr(dotsum, FB);
            spr = floor_shr($signed({48'd0, stiff}) * ($signed({31'd0, len})
                - $signed({33'd0, it.rest_length})), GAIN_BITS);
            dmp = floor_shr($signed({48'd0, damp}) * dotv, GAIN_BITS);
            t = spr - dmp;
            r.force_x = sat(floor_shr(t * n[0], FB));
            r.force_y = sat(floor_shr(t * n[1], FB));
            r.force_z = sat(floor_shr(t * n[2], FB));
            pending.push_back(r);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %h", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected %0d %0d %0d z%0b got %0d %0d %0d z%0b",
                        want.force_x, want.force_y, want.force_z, want.zero_length,
                        got.force_x, got.force_y, got.force_z, got.zero_length);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_ready;
    item_t item = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    result_t result;
    logic cfg_we = 1'b0;
    logic cfg_index = REG_STIFFNESS;
    logic [GAIN_BITS-1:0] cfg_data = '0;

    force_scoreboard board = new();
    int idle_pct = 23;
    bit hold_results = 1'b0;
    int quiet_cycles = 0;

    spring_damper_force_core i_dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready), .item(item),
        .result_valid(result_valid), .result_ready(result_ready), .result(result),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (item_valid && item_ready)
            board.note_item(item);
        if (result_valid && result_ready)
            board.check_result(result);
        if ((item_valid && item_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    always @(negedge clk)
    begin
        if (hold_results)
            result_ready <= 1'b0;
        else
            result_ready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && quiet_cycles > STALL_LIMIT)
        begin
            $display("watchdog expired");
            $display("tb_spring_damper_force_core NOT OK");
            $finish;
        end
    end

    task automatic send_item(item_t it);
        while ($urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        @(negedge clk);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_gain(logic idx, logic [GAIN_BITS-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_STIFFNESS)
            board.stiff = val;
        else
            board.damp = val;
        @(negedge clk);
    endtask

    function automatic logic signed [31:0] rand_pos(int scale);
        case (scale)
            0: return $signed($urandom);
            1: return $signed($urandom_range(65535 * 64)) - 32'sd2097152;
            2: return $signed($urandom_range(32)) - 32'sd16;
            default: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
        endcase
    endfunction

    function automatic item_t rand_item();
        item_t it;
        int s;
        s = $urandom_range(9) < 6 ? 1 : $urandom_range(3);
        it.first_x = rand_pos(s);
        it.first_y = rand_pos(s);
        it.first_z = rand_pos(s);
        if ($urandom_range(19) == 0)
        begin
            it.second_x = it.first_x;
            it.second_y = it.first_y;
            it.second_z = it.first_z;
        end
        else
        begin
            it.second_x = rand_pos(s);
            it.second_y = rand_pos(s);
            it.second_z = rand_pos(s);
        end
        s = $urandom_range(3);
        it.rel_motion_x = rand_pos(s);
        it.rel_motion_y = rand_pos(s);
        it.rel_motion_z = rand_pos(s);
        it.rest_length = $urandom_range(1) ? 31'($urandom) : 31'($urandom_range(1 << 22));
        return it;
    endfunction

    task automatic directed();
        item_t it;
        it = '0;
        send_item(it);
        it.rest_length = 31'h7fffffff;
        it.rel_motion_x = 32'sh7fffffff;
        send_item(it);
        it = '0;
        it.second_x = 32'sh00010000;
        it.rest_length = 31'h8000;
        send_item(it);
        it.second_x = 32'sh7fffffff;
        it.first_x = 32'sh80000000;
        it.first_y = 32'sh80000000;
        it.second_y = 32'sh7fffffff;
        it.first_z = 32'sh7fffffff;
        it.second_z = 32'sh80000000;
        it.rest_length = '0;
        send_item(it);
        it.rel_motion_x = 32'sh80000000;
        it.rel_motion_y = 32'sh7fffffff;
        it.rel_motion_z = 32'sh80000000;
        it.rest_length = 31'h7fffffff;
        send_item(it);
        it = '1;
        send_item(it);
        it.second_z = 32'sh0;
        send_item(it);
        it = '0;
        it.second_y = -32'sd1;
        it.rel_motion_y = 32'sh40000000;
        send_item(it);
        for (int k = 0; k < 12; k++)
            send_item(rand_item());
    endtask

    initial
    begin
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        directed();
        drain();
        write_gain(REG_STIFFNESS, 16'hffff);
        write_gain(REG_DAMPING, 16'h0000);
        for (int k = 0; k < 250; k++)
            send_item(rand_item());
        drain();
        write_gain(REG_STIFFNESS, 16'h0000);
        write_gain(REG_DAMPING, 16'hffff);
        idle_pct = 0;
        for (int k = 0; k < 250; k++)
            send_item(rand_item());
        idle_pct = 23;
        hold_results = 1'b1;
        fork
            begin
                repeat (300)
                    @(posedge clk);
                hold_results = 1'b0;
            end
            for (int k = 0; k < 120; k++)
                send_item(rand_item());
        join
        drain();
        write_gain(REG_STIFFNESS, 16'd1000 + 16'($urandom_range(30000)));
        write_gain(REG_DAMPING, 16'($urandom));
        for (int k = 0; k < 200; k++)
            send_item(rand_item());
        drain();
        write_gain(REG_STIFFNESS, STIFFNESS_RESET);
        write_gain(REG_DAMPING, DAMPING_RESET);
        for (int k = 0; k < 210; k++)
            send_item(rand_item());
        drain();
        if (board.errors == 0)
            $display("tb_spring_damper_force_core OK");
        else
            $display("tb_spring_damper_force_core NOT OK");
        $finish;
    end
endmodule

/* spring_damper_force_core.f */
rtl/sdf_pkg.sv
rtl/sdf_sqrt_pipe.sv
rtl/sdf_div_pipe.sv
rtl/sdf_force_pipe.sv
rtl/spring_damper_force_core.sv
bench/tb_spring_damper_force_core.sv
